// ===== rtl/core/gdrc_pkg.sv =====
// shared types, constants and codes of the grid dda ray caster
`timescale 1ns / 1ps
`default_nettype none
package gdrc_pkg;

	localparam int MAP_DIM_DEF = 64;
	localparam int FRAC_BITS   = 10;
	localparam int CELL_W      = 6;
	localparam int DELTA_W     = 18;
	localparam int POS_W       = 16;
	localparam int DIR_W       = 16;
	localparam int VH_W        = 12;
	localparam int MAPREG_W    = 7;
	localparam int QUOT_W      = 22;
	localparam int HEIGHT_W    = 12;
	localparam int SPAN_W      = 11;
	localparam int FRACT_W     = 10;
	localparam int IN_DATA_W   = 120;
	localparam int OUT_DATA_W  = 80;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 12;

	localparam logic [DELTA_W-1:0]  PERP_MAX   = '1;
	localparam logic [HEIGHT_W-1:0] HEIGHT_MAX = '1;
	localparam logic [VH_W-1:0]     VH_MAX     = VH_W'(2048);
	localparam logic [FRAC_BITS:0]  ONE_CELL   = (FRAC_BITS+1)'(1024);

	localparam logic [CFG_IDX_W-1:0] REG_MAP_COLUMNS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAP_ROWS    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_VIEW_HEIGHT = 2'd2;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_CAST  = 1'b1;

	typedef struct packed {
		logic [MAPREG_W-1:0] map_columns;
		logic [MAPREG_W-1:0] map_rows;
		logic [VH_W-1:0]     view_height;
	} cfg_t;

	typedef struct packed {
		logic                     is_ray;
		logic [CELL_W-1:0]        cell_col;
		logic [CELL_W-1:0]        cell_row;
		logic                     cell_is_wall;
		logic [POS_W-1:0]         origin_x;
		logic [POS_W-1:0]         origin_y;
		logic signed [DIR_W-1:0]  dir_x;
		logic signed [DIR_W-1:0]  dir_y;
		logic [DELTA_W-1:0]       delta_x;
		logic [DELTA_W-1:0]       delta_y;
		logic [DELTA_W-1:0]       start_x;
		logic [DELTA_W-1:0]       start_y;
	} item_t;

	typedef struct packed {
		logic                wall_found;
		logic                hit_side;
		logic [CELL_W-1:0]   hit_col;
		logic [CELL_W-1:0]   hit_row;
		logic [DELTA_W-1:0]  perp_distance;
		logic [HEIGHT_W-1:0] column_height;
		logic [SPAN_W-1:0]   span_top;
		logic [SPAN_W-1:0]   span_bottom;
		logic [FRACT_W-1:0]  hit_fraction;
	} result_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_STEP,
		ST_CHECK,
		ST_PERP,
		ST_DIV,
		ST_DONE
	} back_state_t;

endpackage
`default_nettype wire

// ===== rtl/core/grid_dda_ray_caster.sv =====
// top level of the grid dda ray caster
// After reset the block clears its MAP_DIM x MAP_DIM wall map, one cell a cycle,
// and takes no word until that is done; configuration writes are taken at any
// time. A cell write also passes through the back end's done state. A ray
// takes one step and one map read per step of the walk, then pop, distance,
// divide and result; the walk and its one map read port set its cost.
// The front end computes the start distances and queues up to three words
// while a ray walks, and a finished result waits in the output register
// without stalling the walk.
`timescale 1ns / 1ps
`default_nettype none
module grid_dda_ray_caster #(
	parameter int MAP_DIM = gdrc_pkg::MAP_DIM_DEF
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  s_tvalid,
	output logic                                 s_tready,
	// cell_col, cell_row, cell_is_wall, origin_x, origin_y, dir_x, dir_y, delta_x, delta_y
	input  wire  [gdrc_pkg::IN_DATA_W-1:0]       s_tdata,
	// command
	input  wire                                  s_tuser,
	output logic                                 m_tvalid,
	input  wire                                  m_tready,
	// wall_found, hit_side, hit_col, hit_row, perp_distance, column_height,
	// span_top, span_bottom, hit_fraction
	output logic [gdrc_pkg::OUT_DATA_W-1:0]      m_tdata,
	input  wire                                  cfg_we,
	input  wire  [gdrc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire  [gdrc_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import gdrc_pkg::*;

	cfg_t    cfg_q;
	logic    clearing, push, q_full, q_empty, pop;
	item_t   push_item, pop_item;
	result_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.map_columns <= MAPREG_W'(64);
			cfg_q.map_rows    <= MAPREG_W'(64);
			cfg_q.view_height <= VH_W'(480);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MAP_COLUMNS: cfg_q.map_columns <= cfg_data[MAPREG_W-1:0];
				REG_MAP_ROWS:    cfg_q.map_rows    <= cfg_data[MAPREG_W-1:0];
				REG_VIEW_HEIGHT: cfg_q.view_height <= cfg_data[VH_W-1:0];
				default: begin
				end
			endcase
		end
	end

	gdrc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.block     (clearing),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_data   (s_tdata),
		.in_cmd    (s_tuser),
		.push      (push),
		.push_item (push_item),
		.q_full    (q_full)
	);

	gdrc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.pop_item  (pop_item),
		.empty     (q_empty)
	);

	gdrc_back #(.MAP_DIM(MAP_DIM)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.clearing  (clearing),
		.q_empty   (q_empty),
		.q_item    (pop_item),
		.pop       (pop),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res       (res)
	);

	assign m_tdata = {4'b0, res.hit_fraction, res.span_bottom, res.span_top,
		res.column_height, res.perp_distance, res.hit_row, res.hit_col,
		res.hit_side, res.wall_found};
endmodule
`default_nettype wire

// ===== rtl/core/gdrc_ram.sv =====
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module gdrc_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 4096
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire  [$clog2(DEPTH)-1:0] waddr,
	input  wire  [WIDTH-1:0]         wdata,
	input  wire  [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== rtl/core/gdrc_front.sv =====
// front end: takes words, classifies them and computes the ray start distances
`timescale 1ns / 1ps
`default_nettype none
module gdrc_front (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  block,
	input  wire                                  in_valid,
	output logic                                 in_ready,
	input  wire  [gdrc_pkg::IN_DATA_W-1:0]       in_data,
	input  wire                                  in_cmd,
	output logic                                 push,
	output gdrc_pkg::item_t                      push_item,
	input  wire                                  q_full
);
	import gdrc_pkg::*;

	logic   valid_s1;
	item_t  item_s1;
	item_t  item_in;
	logic [FRAC_BITS:0]           fac_x, fac_y;
	logic [FRAC_BITS+DELTA_W:0]   prod_x, prod_y;

	always_comb begin
		item_in.is_ray       = (in_cmd == CMD_CAST);
		item_in.cell_col     = in_data[5:0];
		item_in.cell_row     = in_data[11:6];
		item_in.cell_is_wall = in_data[12];
		item_in.origin_x     = in_data[28:13];
		item_in.origin_y     = in_data[44:29];
		item_in.dir_x        = in_data[60:45];
		item_in.dir_y        = in_data[76:61];
		item_in.delta_x      = in_data[94:77];
		item_in.delta_y      = in_data[112:95];
		// distance to the first grid line on each axis
		fac_x = item_in.dir_x[DIR_W-1] ? {1'b0, item_in.origin_x[FRAC_BITS-1:0]}
			: ONE_CELL - {1'b0, item_in.origin_x[FRAC_BITS-1:0]};
		fac_y = item_in.dir_y[DIR_W-1] ? {1'b0, item_in.origin_y[FRAC_BITS-1:0]}
			: ONE_CELL - {1'b0, item_in.origin_y[FRAC_BITS-1:0]};
		prod_x = fac_x * item_in.delta_x;
		prod_y = fac_y * item_in.delta_y;
		item_in.start_x = prod_x[FRAC_BITS+DELTA_W-1:FRAC_BITS];
		item_in.start_y = prod_y[FRAC_BITS+DELTA_W-1:FRAC_BITS];
	end

	assign in_ready  = !block && (!valid_s1 || !q_full);
	assign push      = valid_s1 && !q_full;
	assign push_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= item_in;
		end
	end
endmodule
`default_nettype wire

// ===== rtl/core/gdrc_queue.sv =====
// two word queue between front and back
`timescale 1ns / 1ps
`default_nettype none
module gdrc_queue (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              push,
	input  gdrc_pkg::item_t  push_item,
	output logic             full,
	input  wire              pop,
	output gdrc_pkg::item_t  pop_item,
	output logic             empty
);
	import gdrc_pkg::*;

	item_t      entry_q [2];
	logic       wptr_q, rptr_q;
	logic [1:0] count_q;

	assign full     = (count_q == 2'd2);
	assign empty    = (count_q == 2'd0);
	assign pop_item = entry_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= !wptr_q;
			end
			if (pop) begin
				rptr_q <= !rptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wptr_q] <= push_item;
		end
	end
endmodule
`default_nettype wire

// ===== rtl/core/gdrc_back.sv =====
// back end: map writes, dda walk, distance divide and result register
`timescale 1ns / 1ps
`default_nettype none
module gdrc_back #(
	parameter int MAP_DIM = gdrc_pkg::MAP_DIM_DEF
) (
	input  wire               clk,
	input  wire               arst_n,
	input  gdrc_pkg::cfg_t    cfg,
	output logic              clearing,
	input  wire               q_empty,
	input  gdrc_pkg::item_t   q_item,
	output logic              pop,
	output logic              res_valid,
	input  wire               res_ready,
	output gdrc_pkg::result_t res
);
	import gdrc_pkg::*;

	localparam int DEPTH = MAP_DIM * MAP_DIM;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = ($clog2(MAP_DIM) + 2 > 8) ? $clog2(MAP_DIM) + 2 : 8;
	localparam int SW    = DELTA_W + $clog2(2 * MAP_DIM + 2);
	localparam int DCW   = $clog2(QUOT_W);
	localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
	localparam logic [AW-1:0] DIM_A     = AW'(MAP_DIM);

	back_state_t state_q, state_d;

	item_t                   item_q;
	logic [SW-1:0]           side_x_q, side_y_q;
	logic signed [CW-1:0]    col_q, row_q;
	logic                    side_q, hit_q;
	logic [AW-1:0]           clr_q;
	logic [DELTA_W-1:0]      perp_q;
	logic [DELTA_W-1:0]      rem_q;
	logic [QUOT_W-1:0]       num_q;
	logic [DCW-1:0]          div_q;
	logic signed [DELTA_W+DIR_W:0] prod_q;
	logic                    out_valid_q;
	result_t                 out_q;

	logic                    take_x, outside;
	logic signed [CW-1:0]    col_n, row_n, cols_s, rows_s;
	logic [SW-1:0]           side_x_n, side_y_n, perp_w;
	logic [AW-1:0]           raddr;
	logic                    rbit;
	logic                    we;
	logic [AW-1:0]           waddr;
	logic                    wdata;
	logic                    cell_ok;
	logic [DELTA_W:0]        trial;
	logic                    qbit;
	logic [VH_W-1:0]         vh;
	logic [HEIGHT_W-1:0]     height;
	logic [SPAN_W-1:0]       half_h, half_v, top;
	logic [HEIGHT_W-1:0]     bottom;
	logic                    load;
	result_t                 res_n;

	gdrc_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_map (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rbit)
	);

	// walk step and map limits
	always_comb begin
		cols_s = (int'(cfg.map_columns) > MAP_DIM) ? CW'(MAP_DIM)
			: CW'({1'b0, cfg.map_columns});
		rows_s = (int'(cfg.map_rows) > MAP_DIM) ? CW'(MAP_DIM)
			: CW'({1'b0, cfg.map_rows});
		take_x   = side_x_q < side_y_q;
		col_n    = col_q;
		row_n    = row_q;
		side_x_n = side_x_q;
		side_y_n = side_y_q;
		if (take_x) begin
			col_n    = item_q.dir_x[DIR_W-1] ? col_q - CW'(1) : col_q + CW'(1);
			side_x_n = side_x_q + SW'(item_q.delta_x);
		end else begin
			row_n    = item_q.dir_y[DIR_W-1] ? row_q - CW'(1) : row_q + CW'(1);
			side_y_n = side_y_q + SW'(item_q.delta_y);
		end
		outside = (col_n < 0) || (row_n < 0) || (col_n >= cols_s) || (row_n >= rows_s);
		raddr = AW'($unsigned(row_n)) * DIM_A + AW'($unsigned(col_n));
	end

	// map write port, shared by the clear sweep and cell writes
	always_comb begin
		cell_ok = (int'(q_item.cell_col) < MAP_DIM) && (int'(q_item.cell_row) < MAP_DIM);
		if (state_q == ST_CLEAR) begin
			we    = 1'b1;
			waddr = clr_q;
			wdata = 1'b0;
		end else begin
			we    = pop && !q_item.is_ray && cell_ok;
			waddr = AW'(q_item.cell_row) * DIM_A + AW'(q_item.cell_col);
			wdata = q_item.cell_is_wall;
		end
	end

	// perpendicular distance, divide step and span
	always_comb begin
		perp_w = side_q ? side_y_q - SW'(item_q.delta_y) : side_x_q - SW'(item_q.delta_x);
		trial  = {rem_q, num_q[QUOT_W-1]};
		qbit   = trial >= {1'b0, perp_q};
		vh     = cfg.view_height;
		if (cfg.view_height == '0) begin
			vh = VH_W'(1);
		end else if (cfg.view_height > VH_MAX) begin
			vh = VH_MAX;
		end
		height = (num_q > QUOT_W'(HEIGHT_MAX)) ? HEIGHT_MAX : num_q[HEIGHT_W-1:0];
		half_h = height[HEIGHT_W-1:1];
		half_v = vh[VH_W-1:1];
		top    = (half_v > half_h) ? half_v - half_h : '0;
		bottom = {1'b0, half_h} + {1'b0, half_v};
		if (bottom >= vh) begin
			bottom = vh - VH_W'(1);
		end
		res_n = '0;
		if (item_q.is_ray) begin
			res_n.wall_found    = hit_q;
			res_n.hit_side      = side_q;
			res_n.hit_col       = col_q[CELL_W-1:0];
			res_n.hit_row       = row_q[CELL_W-1:0];
			res_n.perp_distance = perp_q;
			res_n.column_height = height;
			res_n.span_top      = top;
			res_n.span_bottom   = bottom[SPAN_W-1:0];
			res_n.hit_fraction  = (side_q ? item_q.origin_x[FRACT_W-1:0]
				: item_q.origin_y[FRACT_W-1:0]) + prod_q[23:14];
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		load    = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_q == LAST_ADDR) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (!q_empty) begin
					pop     = 1'b1;
					state_d = q_item.is_ray ? ST_STEP : ST_DONE;
				end
			end
			ST_STEP: begin
				state_d = outside ? ST_PERP : ST_CHECK;
			end
			ST_CHECK: begin
				state_d = rbit ? ST_PERP : ST_STEP;
			end
			ST_PERP: begin
				state_d = ST_DIV;
			end
			ST_DIV: begin
				if (div_q == DCW'(QUOT_W - 1)) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || res_ready) begin
					load    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				item_q   <= q_item;
				side_x_q <= SW'(q_item.start_x);
				side_y_q <= SW'(q_item.start_y);
				col_q    <= CW'(q_item.origin_x[POS_W-1:FRAC_BITS]);
				row_q    <= CW'(q_item.origin_y[POS_W-1:FRAC_BITS]);
				hit_q    <= 1'b0;
				side_q   <= 1'b0;
			end
			ST_STEP: begin
				side_x_q <= side_x_n;
				side_y_q <= side_y_n;
				col_q    <= col_n;
				row_q    <= row_n;
				side_q   <= !take_x;
			end
			ST_CHECK: begin
				hit_q <= rbit;
			end
			ST_PERP: begin
				perp_q <= (perp_w > SW'(PERP_MAX)) ? PERP_MAX : perp_w[DELTA_W-1:0];
				rem_q  <= '0;
				num_q  <= QUOT_W'(vh) << FRAC_BITS;
				div_q  <= '0;
			end
			ST_DIV: begin
				rem_q  <= qbit ? DELTA_W'(trial - {1'b0, perp_q}) : trial[DELTA_W-1:0];
				num_q  <= {num_q[QUOT_W-2:0], qbit};
				div_q  <= div_q + DCW'(1);
				prod_q <= $signed({1'b0, perp_q}) * (side_q ? item_q.dir_x : item_q.dir_y);
			end
			default: begin
			end
		endcase
		if (load) begin
			out_q <= res_n;
		end
	end

	assign clearing  = (state_q == ST_CLEAR);
	assign res_valid = out_valid_q;
	assign res       = out_q;
endmodule
`default_nettype wire
